/* rtl/pcc_pkg.sv */
// ============================================================================
// pcc_pkg
// Shared constants for the Pearson correlation coefficient block.
// ============================================================================
package pcc_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int CORR_W           = 16;
    localparam int COUNT_BITS_DEF   = 20;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int FRAC_SHIFT       = 30;
    localparam int QUO_W            = FRAC_SHIFT + 1;
    localparam int ROOT_W           = 16;
    localparam int Q15_MAX          = 32767;

endpackage

/* rtl/pcc_in_if.sv */
// ============================================================================
// pcc_in_if
// Input channel: one pair of samples per item, with a last-pair flag.
// ============================================================================
interface pcc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pcc_pkg::SAMPLE_W-1:0]  sample_a;
    logic signed [pcc_pkg::SAMPLE_W-1:0]  sample_b;
    logic                                 last_pair;

    modport source (output valid, output sample_a, output sample_b, output last_pair,
                    input ready);
    modport sink   (input valid, input sample_a, input sample_b, input last_pair,
                    output ready);
endinterface

/* rtl/pcc_out_if.sv */
// ============================================================================
// pcc_out_if
// Result channel: correlation in Q1.15 and the pair count of the image.
// ============================================================================
interface pcc_out_if #(
    parameter int CNT_W = pcc_pkg::COUNT_BITS_DEF + 1
);
    logic                               valid;
    logic                               ready;
    logic signed [pcc_pkg::CORR_W-1:0]  correlation;
    logic        [CNT_W-1:0]            pair_count;

    modport source (output valid, output correlation, output pair_count, input ready);
    modport sink   (input valid, input correlation, input pair_count, output ready);
endinterface

/* rtl/pcc_front.sv */
// ============================================================================
// pcc_front
// Accumulates running sums, one pair per cycle while there is room; on the
// last pair pushes a snapshot of count and sums to the queue and clears them.
// ============================================================================
module pcc_front #(
    parameter int COUNT_BITS  = pcc_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF,
    parameter int SNAP_W      = (COUNT_BITS + 1) + 2 * (SAMPLE_BITS + COUNT_BITS + 1)
                                + 3 * (2 * SAMPLE_BITS + COUNT_BITS + 1)
)(
    input  logic              clk,
    input  logic              rst_n,
    pcc_in_if.sink            samples,
    input  logic              room,
    output logic              push,
    output logic [SNAP_W-1:0] snap
);

    localparam int NW = COUNT_BITS + 1;
    localparam int SW = SAMPLE_BITS + COUNT_BITS + 1;
    localparam int QW = 2 * SAMPLE_BITS + COUNT_BITS + 1;

    logic [NW-1:0]        cnt_reg, cnt_next;
    logic signed [SW-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic signed [QW-1:0] sab_reg, sab_next;
    logic [QW-1:0]        saa_reg, saa_next, sbb_reg, sbb_next;

    logic signed [SAMPLE_BITS-1:0]   a_s, b_s;
    logic signed [2*SAMPLE_BITS-1:0] ab, aa, bb;
    logic                            full, accept;

    assign a_s    = samples.sample_a[SAMPLE_BITS-1:0];
    assign b_s    = samples.sample_b[SAMPLE_BITS-1:0];
    assign ab     = a_s * b_s;
    assign aa     = a_s * a_s;
    assign bb     = b_s * b_s;
    assign full   = cnt_reg[NW-1];
    assign samples.ready = room;
    assign accept = samples.valid && room;
    assign push   = accept && samples.last_pair;

    always_comb
    begin
        if (full)
        begin
            cnt_next = cnt_reg;
            sa_next  = sa_reg;
            sb_next  = sb_reg;
            sab_next = sab_reg;
            saa_next = saa_reg;
            sbb_next = sbb_reg;
        end
        else
        begin
            cnt_next = cnt_reg + NW'(1);
            sa_next  = sa_reg + SW'(a_s);
            sb_next  = sb_reg + SW'(b_s);
            sab_next = sab_reg + QW'(ab);
            saa_next = saa_reg + QW'(aa);
            sbb_next = sbb_reg + QW'(bb);
        end
    end

    assign snap = {cnt_next, sa_next, sb_next, sab_next, saa_next, sbb_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sa_reg  <= '0;
            sb_reg  <= '0;
            sab_reg <= '0;
            saa_reg <= '0;
            sbb_reg <= '0;
        end
        else if (accept)
        begin
            if (samples.last_pair)
            begin
                cnt_reg <= '0;
                sa_reg  <= '0;
                sb_reg  <= '0;
                sab_reg <= '0;
                saa_reg <= '0;
                sbb_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                sa_reg  <= sa_next;
                sb_reg  <= sb_next;
                sab_reg <= sab_next;
                saa_reg <= saa_next;
                sbb_reg <= sbb_next;
            end
        end
    end

endmodule

/* rtl/pcc_queue.sv */
// ============================================================================
// pcc_queue
// Two-entry queue of image snapshots between front and back.
// ============================================================================
module pcc_queue #(
    parameter int W = 8
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    output logic         room,
    input  logic         pop,
    output logic         rd_valid,
    output logic [W-1:0] rd_data
);

    logic [W-1:0] d_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   cnt_reg;

    assign room     = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = d_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            d_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/pcc_mul.sv */
// ============================================================================
// pcc_mul
// Serial shift-add multiplier, one multiplier bit per cycle.
// ============================================================================
module pcc_mul #(
    parameter int PW = 76
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [PW-1:0]   a,
    input  logic [PW-1:0]   b,
    output logic            done,
    output logic [2*PW-1:0] product
);

    localparam int CW = $clog2(PW + 1);

    logic [2*PW-1:0] mcand_reg, acc_reg;
    logic [PW-1:0]   mplier_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;

    assign done    = busy_reg && (cnt_reg == '0);
    assign product = acc_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= (2*PW)'(a);
            mplier_reg <= b;
            acc_reg    <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(PW);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

/* rtl/pcc_back.sv */
// ============================================================================
// pcc_back
// Per-image sequencer: numerator and variance terms through the shared
// multiplier, restoring division, bitwise square root, Q1.15 result.
// ============================================================================
module pcc_back #(
    parameter int COUNT_BITS  = pcc_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF,
    parameter int SNAP_W      = (COUNT_BITS + 1) + 2 * (SAMPLE_BITS + COUNT_BITS + 1)
                                + 3 * (2 * SAMPLE_BITS + COUNT_BITS + 1)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              snap_valid,
    input  logic [SNAP_W-1:0] snap,
    output logic              pop,
    pcc_out_if.source         result
);

    localparam int NW = COUNT_BITS + 1;
    localparam int SW = SAMPLE_BITS + COUNT_BITS + 1;
    localparam int QW = 2 * SAMPLE_BITS + COUNT_BITS + 1;
    localparam int PW = 2 * (SAMPLE_BITS + COUNT_BITS) + 4;
    localparam int RW = 2 * PW + pcc_pkg::FRAC_SHIFT;
    localparam int QUO_W = pcc_pkg::QUO_W;
    localparam int RT_W  = pcc_pkg::ROOT_W;
    localparam int CRW   = pcc_pkg::CORR_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MUL_GO   = 3'd1;
    localparam logic [2:0] S_MUL_WAIT = 3'd2;
    localparam logic [2:0] S_NUM      = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_SQRT     = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    localparam logic [2:0] OP_NSAB = 3'd0;
    localparam logic [2:0] OP_SASB = 3'd1;
    localparam logic [2:0] OP_NSAA = 3'd2;
    localparam logic [2:0] OP_SASA = 3'd3;
    localparam logic [2:0] OP_NSBB = 3'd4;
    localparam logic [2:0] OP_SBSB = 3'd5;
    localparam logic [2:0] OP_VAVB = 3'd6;
    localparam logic [2:0] OP_NUM2 = 3'd7;

    logic [2:0]      state_reg, op_reg;
    logic [4:0]      step_reg;
    logic [NW-1:0]   n_reg;
    logic [SW-1:0]   sa_mag_reg, sb_mag_reg;
    logic [QW-1:0]   sab_mag_reg, saa_reg, sbb_reg;
    logic            neg1_reg, neg2_reg, neg_reg;
    logic [PW-1:0]   res_reg [6];
    logic [PW-1:0]   num_reg;
    logic [2*PW-1:0] den_reg;
    logic [RW-1:0]   rem_reg, dsr_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [RT_W-1:0] root_reg, bit_reg;
    logic signed [CRW-1:0] corr_reg;

    logic [NW-1:0]        s_n;
    logic signed [SW-1:0] s_sa, s_sb;
    logic signed [QW-1:0] s_sab;
    logic [QW-1:0]        s_saa, s_sbb;

    logic            mul_start, mul_done;
    logic [PW-1:0]   mul_a, mul_b;
    logic [2*PW-1:0] mul_p;

    logic signed [PW+1:0] t1_s, t2_s, num_s;
    logic [PW+1:0]        num_abs;
    logic [RT_W-1:0]      trial;
    logic [2*RT_W-1:0]    trial_sq;
    logic [CRW-1:0]       mag;

    assign {s_n, s_sa, s_sb, s_sab, s_saa, s_sbb} = snap;

    always_comb
    begin
        case (op_reg)
            OP_NSAB: begin mul_a = PW'(n_reg);      mul_b = PW'(sab_mag_reg); end
            OP_SASB: begin mul_a = PW'(sa_mag_reg); mul_b = PW'(sb_mag_reg);  end
            OP_NSAA: begin mul_a = PW'(n_reg);      mul_b = PW'(saa_reg);     end
            OP_SASA: begin mul_a = PW'(sa_mag_reg); mul_b = PW'(sa_mag_reg);  end
            OP_NSBB: begin mul_a = PW'(n_reg);      mul_b = PW'(sbb_reg);     end
            OP_SBSB: begin mul_a = PW'(sb_mag_reg); mul_b = PW'(sb_mag_reg);  end
            OP_VAVB: begin mul_a = res_reg[2] - res_reg[3]; mul_b = res_reg[4] - res_reg[5]; end
            default: begin mul_a = num_reg;         mul_b = num_reg;          end
        endcase
    end

    assign mul_start = (state_reg == S_MUL_GO);

    pcc_mul #(.PW(PW)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign t1_s    = neg1_reg ? -$signed((PW+2)'(res_reg[0])) : $signed((PW+2)'(res_reg[0]));
    assign t2_s    = neg2_reg ? -$signed((PW+2)'(res_reg[1])) : $signed((PW+2)'(res_reg[1]));
    assign num_s   = t1_s - t2_s;
    assign num_abs = num_s[PW+1] ? (PW+2)'(-num_s) : (PW+2)'(num_s);

    assign trial    = root_reg | bit_reg;
    assign trial_sq = trial * trial;
    assign mag      = root_reg[RT_W-1] ? CRW'(pcc_pkg::Q15_MAX) : CRW'(root_reg);

    assign pop                = (state_reg == S_IDLE) && snap_valid;
    assign result.valid       = (state_reg == S_OUT);
    assign result.correlation = corr_reg;
    assign result.pair_count  = n_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            n_reg       <= s_n;
            sa_mag_reg  <= s_sa[SW-1] ? SW'(-s_sa) : SW'(s_sa);
            sb_mag_reg  <= s_sb[SW-1] ? SW'(-s_sb) : SW'(s_sb);
            sab_mag_reg <= s_sab[QW-1] ? QW'(-s_sab) : QW'(s_sab);
            saa_reg     <= s_saa;
            sbb_reg     <= s_sbb;
            neg1_reg    <= s_sab[QW-1];
            neg2_reg    <= s_sa[SW-1] ^ s_sb[SW-1];
        end
        if ((state_reg == S_MUL_WAIT) && mul_done)
        begin
            case (op_reg)
                OP_VAVB: den_reg <= mul_p;
                OP_NUM2:
                begin
                    rem_reg <= {mul_p, {pcc_pkg::FRAC_SHIFT{1'b0}}};
                    dsr_reg <= {den_reg, {pcc_pkg::FRAC_SHIFT{1'b0}}};
                end
                default: res_reg[op_reg] <= mul_p[PW-1:0];
            endcase
        end
        case (state_reg)
            S_NUM:
            begin
                num_reg  <= num_abs[PW-1:0];
                neg_reg  <= num_s[PW+1];
                corr_reg <= '0;
            end
            S_DIV:
            begin
                if (rem_reg >= dsr_reg)
                begin
                    rem_reg <= rem_reg - dsr_reg;
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                dsr_reg <= dsr_reg >> 1;
            end
            S_SQRT:
            begin
                if (trial_sq <= (2*RT_W)'(quo_reg))
                begin
                    root_reg <= trial;
                end
                bit_reg <= bit_reg >> 1;
            end
            S_FIN:
            begin
                corr_reg <= neg_reg ? -$signed(mag) : $signed(mag);
            end
            default:
            begin
                root_reg <= '0;
                bit_reg  <= {1'b1, {(RT_W-1){1'b0}}};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NSAB;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (snap_valid)
                    begin
                        op_reg    <= OP_NSAB;
                        state_reg <= S_MUL_GO;
                    end
                end
                S_MUL_GO:
                begin
                    state_reg <= S_MUL_WAIT;
                end
                S_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (op_reg == OP_SASB)
                        begin
                            state_reg <= S_NUM;
                        end
                        else if (op_reg == OP_NUM2)
                        begin
                            step_reg  <= 5'(QUO_W - 1);
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            op_reg    <= op_reg + 3'd1;
                            state_reg <= S_MUL_GO;
                        end
                    end
                end
                S_NUM:
                begin
                    if (num_s == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        op_reg    <= OP_NSAA;
                        state_reg <= S_MUL_GO;
                    end
                end
                S_DIV:
                begin
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == '0)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (result.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/pearson_correlation_coefficient.sv */
// ============================================================================
// pearson_correlation_coefficient
// Streaming Pearson correlation of two images in signed Q1.15.
// ============================================================================
// Pairs are taken one per cycle while the two-entry snapshot queue has room;
// the last pair of an image closes its sums and hands them to the back end.
// The back end's time per image is set by the serial shift-add multiplier,
// PW = 2*(SAMPLE_BITS+COUNT_BITS)+4 bits wide, that forms the numerator,
// the variance terms and their products; it takes a new snapshot only when
// idle. Images shorter than that fill the queue and stall the input until
// the back end drains a snapshot.
module pearson_correlation_coefficient #(
    parameter int COUNT_BITS  = pcc_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    pcc_in_if.sink    samples,
    pcc_out_if.source result
);

    localparam int SNAP_W = (COUNT_BITS + 1) + 2 * (SAMPLE_BITS + COUNT_BITS + 1)
                            + 3 * (2 * SAMPLE_BITS + COUNT_BITS + 1);

    logic              push, room, pop, q_valid;
    logic [SNAP_W-1:0] wr_snap, rd_snap;

    pcc_front #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SNAP_W      (SNAP_W)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .room    (room),
        .push    (push),
        .snap    (wr_snap)
    );

    pcc_queue #(.W(SNAP_W)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (wr_snap),
        .room     (room),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_data  (rd_snap)
    );

    pcc_back #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SNAP_W      (SNAP_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (q_valid),
        .snap       (rd_snap),
        .pop        (pop),
        .result     (result)
    );

endmodule
